@@ design/ppne_pkg.sv @@
// Shared types, widths and tables for the point-to-plane normal equation block.
// No dependencies; used by every module in design/.
package ppne_pkg;

  localparam int SRC_W       = 20;
  localparam int NRM_W       = 16;
  localparam int OP_W        = 25;
  localparam int PROD_W      = 2 * OP_W;
  localparam int TMP_W       = 40;
  localparam int ACC_W       = 64;
  localparam int IDX_W       = 5;
  localparam int CNT_OUT_W   = 20;
  localparam int STEP_W      = 6;
  localparam int NUM_A       = 21;
  localparam int NUM_B       = 6;
  localparam int NUM_ENT     = NUM_A + NUM_B;
  localparam int LAST_IDX    = NUM_ENT - 1;
  localparam int IN_DATA_W   = 168;
  localparam int OUT_DATA_W  = 96;
  localparam int MAX_PAIRS_DEF = 524288;

  // Step schedule of the shared multiplier
  localparam logic [STEP_W-1:0] STEP_CX0A  = 6'd0;
  localparam logic [STEP_W-1:0] STEP_CX0B  = 6'd1;
  localparam logic [STEP_W-1:0] STEP_CX1A  = 6'd2;
  localparam logic [STEP_W-1:0] STEP_CX1B  = 6'd3;
  localparam logic [STEP_W-1:0] STEP_CX2A  = 6'd4;
  localparam logic [STEP_W-1:0] STEP_CX2B  = 6'd5;
  localparam logic [STEP_W-1:0] STEP_RX    = 6'd6;
  localparam logic [STEP_W-1:0] STEP_RY    = 6'd7;
  localparam logic [STEP_W-1:0] STEP_RZ    = 6'd8;
  localparam logic [STEP_W-1:0] STEP_A0    = 6'd9;
  localparam logic [STEP_W-1:0] STEP_B0    = 6'd30;
  localparam logic [STEP_W-1:0] NUM_STEPS  = 6'd36;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              emit_load;
    logic [IDX_W-1:0]  emit_idx;
  } ppne_cmd_t;

  // Row and column of upper-triangle entry k, row-major: {row, col}
  function automatic logic [5:0] tri_pair(input logic [IDX_W-1:0] k);
    logic [5:0] rc;
    rc = 6'o00;
    case (k)
      5'd0:  rc = 6'o00;
      5'd1:  rc = 6'o01;
      5'd2:  rc = 6'o02;
      5'd3:  rc = 6'o03;
      5'd4:  rc = 6'o04;
      5'd5:  rc = 6'o05;
      5'd6:  rc = 6'o11;
      5'd7:  rc = 6'o12;
      5'd8:  rc = 6'o13;
      5'd9:  rc = 6'o14;
      5'd10: rc = 6'o15;
      5'd11: rc = 6'o22;
      5'd12: rc = 6'o23;
      5'd13: rc = 6'o24;
      5'd14: rc = 6'o25;
      5'd15: rc = 6'o33;
      5'd16: rc = 6'o34;
      5'd17: rc = 6'o35;
      5'd18: rc = 6'o44;
      5'd19: rc = 6'o45;
      5'd20: rc = 6'o55;
      default: rc = 6'o00;
    endcase
    return rc;
  endfunction

endpackage

@@ design/ppne_ctrl.sv @@
// Sequencer for the normal equation block: input capture, multiply schedule, emission.
// Depends on ppne_pkg.
module ppne_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic                m_tlast,
  output ppne_pkg::ppne_cmd_t cmd
);

  typedef enum logic [1:0] {IDLE, CALC, EMIT} state_t;

  state_t                       state;
  logic [ppne_pkg::STEP_W-1:0]  step;
  logic [ppne_pkg::IDX_W-1:0]   eidx;
  logic                         last_q;

  // Command decode
  always_comb begin
    cmd           = '0;
    cmd.step      = step;
    cmd.emit_idx  = eidx;
    s_tready      = (state == IDLE);
    cmd.load      = s_tready && s_tvalid;
    cmd.issue     = (state == CALC) && (step < ppne_pkg::NUM_STEPS);
    cmd.emit_load = (state == EMIT) && (eidx < ppne_pkg::IDX_W'(ppne_pkg::NUM_ENT)) &&
                    (!m_tvalid || m_tready);
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step     <= '0;
      eidx     <= '0;
      last_q   <= 1'b0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.load) begin
            last_q <= s_tlast;
            step   <= '0;
            state  <= CALC;
          end
        end
        CALC: begin
          // the extra step at NUM_STEPS drains the product register
          if (step == ppne_pkg::NUM_STEPS) begin
            eidx  <= '0;
            state <= last_q ? EMIT : IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        EMIT: begin
          if (cmd.emit_load) begin
            m_tvalid <= 1'b1;
            m_tlast  <= (eidx == ppne_pkg::IDX_W'(ppne_pkg::LAST_IDX));
            eidx     <= eidx + 1'b1;
          end else if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
            m_tlast  <= 1'b0;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ design/ppne_datapath.sv @@
// Datapath: shared multiplier, rounding, saturating accumulators, pair count, output beat.
// Depends on ppne_pkg.
module ppne_datapath #(
  parameter int MAX_PAIRS = ppne_pkg::MAX_PAIRS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppne_pkg::ppne_cmd_t               cmd,
  input  logic [ppne_pkg::IN_DATA_W-1:0]    in_data,
  output logic [ppne_pkg::OUT_DATA_W-1:0]   out_data
);

  localparam int OP_W   = ppne_pkg::OP_W;
  localparam int TMP_W  = ppne_pkg::TMP_W;
  localparam int ACC_W  = ppne_pkg::ACC_W;
  localparam int PCNT_W = $clog2(MAX_PAIRS + 1);

  logic signed [ppne_pkg::SRC_W-1:0] sx, sy, sz, dx, dy, dz;
  logic signed [ppne_pkg::NRM_W-1:0] nx, ny, nz;
  logic signed [OP_W-1:0]   a0, a1, a2, a3, a4, a5, r;
  logic signed [OP_W-1:0]   opa, opb;
  logic signed [ppne_pkg::PROD_W-1:0] prod;
  logic [ppne_pkg::STEP_W-1:0] ptag;
  logic                     pv;
  logic signed [TMP_W-1:0]  t;
  logic signed [TMP_W-1:0]  pt;
  logic signed [ACC_W-1:0]  sums [ppne_pkg::NUM_ENT];
  logic [ppne_pkg::IDX_W-1:0] addr;
  logic signed [ACC_W-1:0]  rd;
  logic signed [ACC_W:0]    wide;
  logic signed [ACC_W-1:0]  sat;
  logic [PCNT_W-1:0]        cnt;
  logic [PCNT_W+ppne_pkg::CNT_OUT_W-1:0] cnt_ext;
  logic [5:0]               rc;
  logic [ppne_pkg::IDX_W-1:0] k;

  function automatic logic signed [OP_W-1:0] rnd14(input logic signed [TMP_W-1:0] x);
    logic signed [TMP_W-1:0] y;
    y = (x + TMP_W'(8192)) >>> 14;
    return OP_W'(y);
  endfunction

  function automatic logic signed [OP_W-1:0] pick(input logic [2:0] i,
      input logic signed [OP_W-1:0] v0, input logic signed [OP_W-1:0] v1,
      input logic signed [OP_W-1:0] v2, input logic signed [OP_W-1:0] v3,
      input logic signed [OP_W-1:0] v4, input logic signed [OP_W-1:0] v5);
    logic signed [OP_W-1:0] v;
    case (i)
      3'd0: v = v0;
      3'd1: v = v1;
      3'd2: v = v2;
      3'd3: v = v3;
      3'd4: v = v4;
      default: v = v5;
    endcase
    return v;
  endfunction

  // Select multiplier operands for the current step
  always_comb begin
    k   = ppne_pkg::IDX_W'(cmd.step - ppne_pkg::STEP_A0);
    rc  = ppne_pkg::tri_pair(k);
    opa = '0;
    opb = '0;
    if (cmd.step >= ppne_pkg::STEP_B0) begin
      opa = pick(3'(cmd.step - ppne_pkg::STEP_B0), a0, a1, a2, a3, a4, a5);
      opb = r;
    end else if (cmd.step >= ppne_pkg::STEP_A0) begin
      opa = pick(rc[5:3], a0, a1, a2, a3, a4, a5);
      opb = pick(rc[2:0], a0, a1, a2, a3, a4, a5);
    end else begin
      case (cmd.step)
        ppne_pkg::STEP_CX0A: begin opa = OP_W'(sy); opb = OP_W'(nz); end
        ppne_pkg::STEP_CX0B: begin opa = OP_W'(sz); opb = OP_W'(ny); end
        ppne_pkg::STEP_CX1A: begin opa = OP_W'(sz); opb = OP_W'(nx); end
        ppne_pkg::STEP_CX1B: begin opa = OP_W'(sx); opb = OP_W'(nz); end
        ppne_pkg::STEP_CX2A: begin opa = OP_W'(sx); opb = OP_W'(ny); end
        ppne_pkg::STEP_CX2B: begin opa = OP_W'(sy); opb = OP_W'(nx); end
        ppne_pkg::STEP_RX: begin opa = OP_W'(dx) - OP_W'(sx); opb = OP_W'(nx); end
        ppne_pkg::STEP_RY: begin opa = OP_W'(dy) - OP_W'(sy); opb = OP_W'(ny); end
        ppne_pkg::STEP_RZ: begin opa = OP_W'(dz) - OP_W'(sz); opb = OP_W'(nz); end
        default: begin opa = '0; opb = '0; end
      endcase
    end
  end

  // Accumulator read port and saturating add
  always_comb begin
    addr = cmd.emit_load ? cmd.emit_idx : ppne_pkg::IDX_W'(ptag - ppne_pkg::STEP_A0);
    rd   = sums[addr];
    wide = {rd[ACC_W-1], rd} + (ACC_W+1)'(prod);
    if (wide[ACC_W] != wide[ACC_W-1])
      sat = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else
      sat = wide[ACC_W-1:0];
    pt      = TMP_W'(prod);
    cnt_ext = {{ppne_pkg::CNT_OUT_W{1'b0}}, cnt};
  end

  // Capture inputs, multiply, consume products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= in_data[19:0];    sy <= in_data[39:20];   sz <= in_data[59:40];
      dx <= in_data[79:60];   dy <= in_data[99:80];   dz <= in_data[119:100];
      nx <= in_data[135:120]; ny <= in_data[151:136]; nz <= in_data[167:152];
      a3 <= OP_W'($signed(in_data[135:120])) <<< 2;
      a4 <= OP_W'($signed(in_data[151:136])) <<< 2;
      a5 <= OP_W'($signed(in_data[167:152])) <<< 2;
    end
    prod <= opa * opb;
    ptag <= cmd.step;
    if (pv) begin
      case (ptag)
        ppne_pkg::STEP_CX0A, ppne_pkg::STEP_CX1A,
        ppne_pkg::STEP_CX2A, ppne_pkg::STEP_RX: t <= pt;
        ppne_pkg::STEP_CX0B: a0 <= rnd14(t - pt);
        ppne_pkg::STEP_CX1B: a1 <= rnd14(t - pt);
        ppne_pkg::STEP_CX2B: a2 <= rnd14(t - pt);
        ppne_pkg::STEP_RY:   t  <= t + pt;
        ppne_pkg::STEP_RZ:   r  <= rnd14(t + pt);
        default: ;
      endcase
    end
    if (cmd.emit_load)
      out_data <= {7'd0, cnt_ext[ppne_pkg::CNT_OUT_W-1:0], rd, cmd.emit_idx};
  end

  // Control: product valid, accumulators, pair count
  always_ff @(posedge clk) begin
    if (rst) begin
      pv  <= 1'b0;
      cnt <= '0;
      for (int i = 0; i < ppne_pkg::NUM_ENT; i++) sums[i] <= '0;
    end else begin
      pv <= cmd.issue;
      if (cmd.load && (cnt < PCNT_W'(MAX_PAIRS)))
        cnt <= cnt + 1'b1;
      if (cmd.emit_load) begin
        // drain and clear each sum as it leaves
        sums[addr] <= '0;
        if (cmd.emit_idx == ppne_pkg::IDX_W'(ppne_pkg::LAST_IDX))
          cnt <= '0;
      end else if (pv && ptag >= ppne_pkg::STEP_A0) begin
        sums[addr] <= sat;
      end
    end
  end

endmodule

@@ design/point_plane_normal_equations.sv @@
// Point-to-plane normal equation accumulator, top level.
// Each correspondence is computed in 36 steps through one shared 25x25 multiplier, plus a
// drain step; the block takes no new input beat until the last one is done.
// A last beat adds 27 output beats before the next input.
// Reset (rst, synchronous, active high) clears the sums, pair count and all control state.
// Depends on ppne_pkg, ppne_ctrl, ppne_datapath.
module point_plane_normal_equations #(
  parameter int MAX_PAIRS = ppne_pkg::MAX_PAIRS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // src_x, src_y, src_z, dst_x, dst_y, dst_z, nrm_x, nrm_y, nrm_z
  input  logic [ppne_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // entry_index, entry_value, pair_count, zero pad
  output logic [ppne_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tlast
);

  ppne_pkg::ppne_cmd_t cmd;

  ppne_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
    .cmd(cmd)
  );

  ppne_datapath #(.MAX_PAIRS(MAX_PAIRS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_data(s_tdata), .out_data(m_tdata)
  );

  // Never take input while a result beat is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input accepted during emission");

  // Last beat carries the final entry index
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[4:0] == 5'(ppne_pkg::LAST_IDX))
    else $error("last beat with wrong index");

  // Run ends after the last beat
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("beat after end of run");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the point-to-plane normal equation accumulator.
// Streams correspondences into the block, predicts the 27-entry result run of each
// frame and checks every output beat. Depends on ppne_pkg and the design top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct {
    logic signed [ppne_pkg::SRC_W-1:0] src_x, src_y, src_z;
    logic signed [ppne_pkg::SRC_W-1:0] dst_x, dst_y, dst_z;
    logic signed [ppne_pkg::NRM_W-1:0] nrm_x, nrm_y, nrm_z;
    logic                              last_pair;
  } corr_t;

  typedef struct {
    logic [ppne_pkg::IDX_W-1:0]     entry_index;
    logic [ppne_pkg::ACC_W-1:0]     entry_value;
    logic [ppne_pkg::CNT_OUT_W-1:0] pair_count;
    logic                           last_entry;
  } entry_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [ppne_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [ppne_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tlast;

  // Predicted block state
  longint mat_sum [ppne_pkg::NUM_A];
  longint rhs_sum [ppne_pkg::NUM_B];
  int     pair_tally;
  entry_t expected_entries [$];

  int  error_count;
  int  pairs_sent;
  int  frames_sent;
  int  entries_checked;
  int  stall_left;
  int  idle_cycles;
  bit  idle_on;

  point_plane_normal_equations dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint round_q16(input longint x);
    return (x + 64'sd8192) >>> 14;
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  // Accumulate one correspondence; on the last one queue the run and clear
  function automatic void accumulate_pair(input corr_t p);
    longint sx, sy, sz, dx, dy, dz, nx, ny, nz, r;
    longint row [6];
    int     k;
    entry_t e;
    sx = p.src_x; sy = p.src_y; sz = p.src_z;
    dx = p.dst_x; dy = p.dst_y; dz = p.dst_z;
    nx = p.nrm_x; ny = p.nrm_y; nz = p.nrm_z;
    row[0] = round_q16(sy * nz - sz * ny);
    row[1] = round_q16(sz * nx - sx * nz);
    row[2] = round_q16(sx * ny - sy * nx);
    row[3] = nx * 4;
    row[4] = ny * 4;
    row[5] = nz * 4;
    r = round_q16(nx * (dx - sx) + ny * (dy - sy) + nz * (dz - sz));
    k = 0;
    for (int i = 0; i < 6; i++) begin
      for (int j = i; j < 6; j++) begin
        mat_sum[k] = sat_sum(mat_sum[k], row[i] * row[j]);
        k++;
      end
    end
    for (int i = 0; i < ppne_pkg::NUM_B; i++) rhs_sum[i] = sat_sum(rhs_sum[i], row[i] * r);
    if (pair_tally < ppne_pkg::MAX_PAIRS_DEF) pair_tally++;
    if (p.last_pair) begin
      for (int i = 0; i < ppne_pkg::NUM_ENT; i++) begin
        e.entry_index = i[ppne_pkg::IDX_W-1:0];
        e.entry_value = (i < ppne_pkg::NUM_A) ? mat_sum[i] : rhs_sum[i - ppne_pkg::NUM_A];
        e.pair_count  = pair_tally[ppne_pkg::CNT_OUT_W-1:0];
        e.last_entry  = (i == ppne_pkg::LAST_IDX);
        expected_entries.push_back(e);
      end
      foreach (mat_sum[i]) mat_sum[i] = 0;
      foreach (rhs_sum[i]) rhs_sum[i] = 0;
      pair_tally = 0;
    end
  endfunction

  // Drive one correspondence and wait for its beat to be taken
  task automatic send_pair(input corr_t p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p.nrm_z, p.nrm_y, p.nrm_x, p.dst_z, p.dst_y, p.dst_x,
                 p.src_z, p.src_y, p.src_x};
    s_tlast  <= p.last_pair;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accumulate_pair(p);
    pairs_sent++;
    if (p.last_pair) frames_sent++;
  endtask

  function automatic corr_t random_pair(input bit last, input bit small_range);
    corr_t p;
    if (small_range) begin
      p.src_x = ppne_pkg::SRC_W'($urandom_range(0, 131071) - 65536);
      p.src_y = ppne_pkg::SRC_W'($urandom_range(0, 131071) - 65536);
      p.src_z = ppne_pkg::SRC_W'($urandom_range(0, 131071) - 65536);
      p.dst_x = ppne_pkg::SRC_W'(p.src_x + $urandom_range(0, 4095) - 2048);
      p.dst_y = ppne_pkg::SRC_W'(p.src_y + $urandom_range(0, 4095) - 2048);
      p.dst_z = ppne_pkg::SRC_W'(p.src_z + $urandom_range(0, 4095) - 2048);
      p.nrm_x = ppne_pkg::NRM_W'($urandom_range(0, 32767) - 16384);
      p.nrm_y = ppne_pkg::NRM_W'($urandom_range(0, 32767) - 16384);
      p.nrm_z = ppne_pkg::NRM_W'($urandom_range(0, 32767) - 16384);
    end else begin
      p.src_x = ppne_pkg::SRC_W'($urandom);
      p.src_y = ppne_pkg::SRC_W'($urandom);
      p.src_z = ppne_pkg::SRC_W'($urandom);
      p.dst_x = ppne_pkg::SRC_W'($urandom);
      p.dst_y = ppne_pkg::SRC_W'($urandom);
      p.dst_z = ppne_pkg::SRC_W'($urandom);
      p.nrm_x = ppne_pkg::NRM_W'($urandom);
      p.nrm_y = ppne_pkg::NRM_W'($urandom);
      p.nrm_z = ppne_pkg::NRM_W'($urandom);
    end
    p.last_pair = last;
    return p;
  endfunction

  function automatic corr_t uniform_pair(input int sv, input int dv, input int nv,
                                         input bit last);
    corr_t p;
    p.src_x = ppne_pkg::SRC_W'(sv);
    p.src_y = ppne_pkg::SRC_W'(sv);
    p.src_z = ppne_pkg::SRC_W'(sv);
    p.dst_x = ppne_pkg::SRC_W'(dv);
    p.dst_y = ppne_pkg::SRC_W'(dv);
    p.dst_z = ppne_pkg::SRC_W'(dv);
    p.nrm_x = ppne_pkg::NRM_W'(nv);
    p.nrm_y = ppne_pkg::NRM_W'(nv);
    p.nrm_z = ppne_pkg::NRM_W'(nv);
    p.last_pair = last;
    return p;
  endfunction

  // Drop the input beat, then wait until every predicted entry has been seen
  task automatic wait_run_done();
    s_tvalid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
  endtask

  // Field extremes, each in its own single-pair frame
  task automatic test_extremes();
    send_pair(uniform_pair(524287, -524288, 32767, 1'b1));
    send_pair(uniform_pair(-524288, 524287, -32768, 1'b1));
    send_pair(uniform_pair(-524288, 524287, 32767, 1'b1));
    send_pair(uniform_pair(524287, 524287, -32768, 1'b1));
    send_pair(uniform_pair(-1, 0, -1, 1'b1));
    wait_run_done();
  endtask

  // Zero and non-unit normals, mixed signs per axis
  task automatic test_degenerate_normals();
    corr_t p;
    send_pair(uniform_pair(12345, -54321, 0, 1'b1));
    p = random_pair(1'b0, 1'b0);
    p.nrm_x = 16'sh7FFF; p.nrm_y = 16'sh7FFF; p.nrm_z = 16'sh8000;
    send_pair(p);
    p = random_pair(1'b0, 1'b0);
    p.nrm_x = '0; p.nrm_y = 16'sh8000; p.nrm_z = '0;
    send_pair(p);
    p = random_pair(1'b1, 1'b0);
    p.nrm_x = 16'sh0001; p.nrm_y = '0; p.nrm_z = 16'shFFFF;
    send_pair(p);
    wait_run_done();
  endtask

  // Multi-pair frame at full magnitude to push the sums hard
  task automatic test_long_extreme_frame();
    for (int i = 0; i < 14; i++)
      send_pair(uniform_pair(524287, -524288, 32767, i == 13));
    wait_run_done();
  endtask

  // Random frames: mostly short, realistic geometry, some full-range noise
  task automatic test_random_frames(input int budget);
    int len;
    int sent;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
        send_pair(random_pair(i == len - 1, $urandom_range(0, 3) != 0));
      sent += len;
    end
    wait_run_done();
  endtask

  // Receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      m_tready   <= 1'b1;
    end
  end

  // Compare each output beat with the oldest predicted entry
  always @(posedge clk) begin
    entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_entries.size() == 0) begin
        $error("unexpected output beat, entry_index %0d", m_tdata[4:0]);
        error_count++;
      end else begin
        want = expected_entries.pop_front();
        entries_checked++;
        if (m_tdata[4:0] !== want.entry_index) begin
          $error("entry_index: expected %0d, actual %0d", want.entry_index, m_tdata[4:0]);
          error_count++;
        end
        if (m_tdata[68:5] !== want.entry_value) begin
          $error("entry_value: expected %0d, actual %0d",
                 $signed(want.entry_value), $signed(m_tdata[68:5]));
          error_count++;
        end
        if (m_tdata[88:69] !== want.pair_count) begin
          $error("pair_count: expected %0d, actual %0d", want.pair_count, m_tdata[88:69]);
          error_count++;
        end
        if (m_tlast !== want.last_entry) begin
          $error("last_entry: expected %0d, actual %0d", want.last_entry, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Abort when neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (mat_sum[i]) mat_sum[i] = 0;
    foreach (rhs_sum[i]) rhs_sum[i] = 0;
    pair_tally      = 0;
    error_count     = 0;
    pairs_sent      = 0;
    frames_sent     = 0;
    entries_checked = 0;
    idle_on         = 1'b1;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_degenerate_normals();
    test_long_extreme_frame();
    test_random_frames(320);
    // Final stretch at full rate on both sides
    idle_on = 1'b0;
    test_random_frames(60);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d correspondences in %0d frames; checked %0d result entries.",
             pairs_sent, frames_sent, entries_checked);
    $display("Covered field extremes, zero and non-unit normals, random frames, stalls.");
    if (error_count == 0 && expected_entries.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
